### hw/rtl/sfla_pkg.sv
// shared constants, codes and helpers of the segregated free list allocator
package sfla_pkg;

  localparam int ARENA_BYTES  = 65536;
  localparam int GRANULE      = 8;
  localparam int MAX_SMALL    = 128;
  localparam int NUM_CLASSES  = 16;
  localparam int REFILL_COUNT = 20;
  localparam int MAX_PASS     = 4;

  localparam int LINKS   = ARENA_BYTES / GRANULE;
  localparam int GSH     = $clog2(GRANULE);
  localparam int GIDX_W  = $clog2(LINKS);
  localparam int LINK_W  = GIDX_W + 1;
  localparam int ADDR_W  = $clog2(ARENA_BYTES) + 1;
  localparam int CLS_W   = $clog2(NUM_CLASSES);
  localparam int SIZE_W  = $clog2(MAX_SMALL) + 1;
  localparam int PASS_W  = $clog2(MAX_PASS);

  localparam int MODE_W  = 2;
  localparam int SZ_W    = 12;
  localparam int BADDR_W = 16;
  localparam int STAT_W  = 2;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(LINKS);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_REALLOC = 2'd2,
    MODE_OTHER   = 2'd3
  } sfla_mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_BIG  = 2'd2,
    ST_ZERO = 2'd3
  } sfla_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_ALLOC,
    S_TAKE,
    S_DIV,
    S_GROW,
    S_POPW,
    S_LINK,
    S_FIN
  } sfla_state_e;

  function automatic logic [SZ_W-1:0] cls_of(input logic [SZ_W-1:0] n);
    logic [SZ_W:0] t;
    t = ({1'b0, n} + (SZ_W+1)'(GRANULE - 1)) >> GSH;
    return SZ_W'(t - (SZ_W+1)'(1));
  endfunction

  function automatic sfla_status_e size_status(input logic [SZ_W-1:0] n);
    sfla_status_e s;
    if (n == '0) begin
      s = ST_ZERO;
    end else if (n > SZ_W'(MAX_SMALL) || cls_of(n) >= SZ_W'(NUM_CLASSES)) begin
      s = ST_BIG;
    end else begin
      s = ST_OK;
    end
    return s;
  endfunction

endpackage

### hw/rtl/segregated_free_list_allocator_unit.sv
// segregated free list allocator: class heads in flops, link store in a synchronous ram
// An item whose class list holds a block reads the next link from the ram in S_ALLOC,
// writes it to the class head in S_POPW and gives its result word from S_FIN; the next
// word can be accepted once the unit is back in S_IDLE. A reallocate first releases the
// old block in S_FREE. An empty class is refilled from the pool in up to four refill
// passes: a carve that subtracts the block size once a cycle when the pool holds fewer
// than 20 blocks, and one link store write per carved block after the first (up to 19).
// A free writes the block into its class list in S_FREE. A stalled result holds the
// unit in S_FIN. The link store has one write or one read port in use per cycle and
// needs no clearing after reset.
module segregated_free_list_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sfla_pkg::MODE_W-1:0]    mode_i,
  input  logic [sfla_pkg::SZ_W-1:0]      request_size_i,
  input  logic [sfla_pkg::SZ_W-1:0]      old_size_i,
  input  logic [sfla_pkg::BADDR_W-1:0]   block_address_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sfla_pkg::BADDR_W-1:0]   granted_address_o,
  output logic [sfla_pkg::STAT_W-1:0]    status_o
);
  import sfla_pkg::*;

  sfla_state_e st_q, st_d;

  logic [MODE_W-1:0]  mode_q;
  logic [SZ_W-1:0]    req_q, old_q;
  logic [BADDR_W-1:0] addr_q;

  logic [LINK_W-1:0] heads_q [NUM_CLASSES];
  logic [ADDR_W-1:0] pool_start_q, pool_start_d;
  logic [ADDR_W-1:0] pool_end_q, pool_end_d;
  logic [ADDR_W-1:0] heap_total_q, heap_total_d;
  logic [ADDR_W-1:0] arena_next_q, arena_next_d;
  logic [CLS_W-1:0]  cls_q, cls_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [PASS_W-1:0] pass_q, pass_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] rem_q, rem_d;
  logic [CLS_W-1:0]  pop_cls_q, pop_cls_d;
  logic              borrow_q, borrow_d;
  logic [BADDR_W-1:0] res_grant_q, res_grant_d;
  sfla_status_e      res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  logic [BADDR_W-1:0] grant_q, grant_d;
  sfla_status_e      status_q, status_d;

  logic [LINK_W-1:0] link_mem [LINKS];
  logic              mem_we, mem_re;
  logic [GIDX_W-1:0] mem_waddr, mem_raddr;
  logic [LINK_W-1:0] mem_wdata, mem_rdata_q;

  logic              hd_we;
  logic [CLS_W-1:0]  hd_idx;
  logic [LINK_W-1:0] hd_wdata;

  logic [SZ_W-1:0]   rel_n, rel_cls, req_cls, left_cls;
  sfla_status_e      rel_st, req_st;
  logic [ADDR_W-1:0] size_x, left, total, want, room, hsix, ru;
  logic              fits_all, fits_one, want_ok, rem_ge, link_done, out_free;
  logic              last_pass, req_hit, found;
  logic [CLS_W-1:0]  bcls;
  logic [LINK_W-1:0] req_head, bhead;

  always_comb begin
    rel_n     = (mode_q == MODE_FREE) ? req_q : old_q;
    rel_cls   = cls_of(rel_n);
    rel_st    = size_status(rel_n);
    req_cls   = cls_of(req_q);
    req_st    = size_status(req_q);
    req_head  = heads_q[req_cls[CLS_W-1:0]];
    req_hit   = !req_head[LINK_W-1];
    size_x    = ADDR_W'(size_q);
    left      = (pool_end_q >= pool_start_q) ? pool_end_q - pool_start_q : '0;
    left_cls  = cls_of(left[SZ_W-1:0]);
    total     = size_x * ADDR_W'(REFILL_COUNT);
    hsix      = heap_total_q >> 4;
    ru        = ((hsix + ADDR_W'(GRANULE - 1)) >> GSH) << GSH;
    want      = (total << 1) + ru;
    room      = ADDR_W'(ARENA_BYTES) - arena_next_q;
    fits_all  = left >= total;
    fits_one  = left >= size_x;
    want_ok   = want <= room;
    rem_ge    = rem_q >= size_x;
    link_done = ptr_q == base_q;
    out_free  = !out_valid_q || out_ready_i;
    last_pass = pass_q == PASS_W'(MAX_PASS - 1);
  end

  always_comb begin
    found = 1'b0;
    bcls  = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (CLS_W'(c) >= cls_q && !heads_q[c][LINK_W-1]) begin
        found = 1'b1;
        bcls  = CLS_W'(c);
      end
    end
    bhead = heads_q[bcls];
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d = (sfla_mode_e'(mode_i) == MODE_ALLOC) ? S_ALLOC : S_FREE;
        end
      end
      S_FREE:  st_d = (mode_q == MODE_FREE) ? S_FIN : S_ALLOC;
      S_ALLOC: begin
        if (req_st != ST_OK) st_d = S_FIN;
        else if (req_hit)    st_d = S_POPW;
        else                 st_d = S_TAKE;
      end
      S_POPW: begin
        if (!borrow_q || last_pass) st_d = S_FIN;
        else                        st_d = S_TAKE;
      end
      S_TAKE: begin
        if (fits_all)      st_d = S_LINK;
        else if (fits_one) st_d = S_DIV;
        else               st_d = S_GROW;
      end
      S_DIV:  st_d = rem_ge ? S_DIV : S_LINK;
      S_LINK: st_d = link_done ? S_FIN : S_LINK;
      S_GROW: begin
        if (want_ok)    st_d = last_pass ? S_FIN : S_TAKE;
        else if (found) st_d = S_POPW;
        else            st_d = S_FIN;
      end
      S_FIN:   st_d = out_free ? S_IDLE : S_FIN;
      default: st_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pool_start_d = pool_start_q;
    pool_end_d   = pool_end_q;
    heap_total_d = heap_total_q;
    arena_next_d = arena_next_q;
    cls_d        = cls_q;
    size_d       = size_q;
    pass_d       = pass_q;
    base_d       = base_q;
    ptr_d        = ptr_q;
    rem_d        = rem_q;
    pop_cls_d    = pop_cls_q;
    borrow_d     = borrow_q;
    res_grant_d  = res_grant_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    grant_d      = grant_q;
    status_d     = status_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    hd_we        = 1'b0;
    hd_idx       = '0;
    hd_wdata     = '0;
    unique case (st_q)
      S_IDLE: ;
      S_FREE: begin
        if (rel_st == ST_OK) begin
          mem_we    = 1'b1;
          mem_waddr = addr_q[GSH +: GIDX_W];
          mem_wdata = heads_q[rel_cls[CLS_W-1:0]];
          hd_we     = 1'b1;
          hd_idx    = rel_cls[CLS_W-1:0];
          hd_wdata  = {1'b0, addr_q[GSH +: GIDX_W]};
        end
        res_grant_d  = '0;
        res_status_d = rel_st;
      end
      S_ALLOC: begin
        res_grant_d  = '0;
        res_status_d = req_st;
        cls_d        = req_cls[CLS_W-1:0];
        size_d       = SIZE_W'((req_cls + SZ_W'(1)) << GSH);
        pass_d       = '0;
        borrow_d     = 1'b0;
        pop_cls_d    = req_cls[CLS_W-1:0];
        if (req_st == ST_OK && req_hit) begin
          mem_re      = 1'b1;
          mem_raddr   = req_head[GIDX_W-1:0];
          res_grant_d = {req_head[GIDX_W-1:0], GSH'(0)};
        end
      end
      S_POPW: begin
        hd_we    = 1'b1;
        hd_idx   = pop_cls_q;
        hd_wdata = mem_rdata_q;
        if (borrow_q) begin
          if (last_pass) begin
            pool_start_d = '0;
            pool_end_d   = '0;
            res_grant_d  = '0;
            res_status_d = ST_OOM;
          end else begin
            pass_d = pass_q + PASS_W'(1);
          end
        end
      end
      S_TAKE: begin
        base_d = pool_start_q;
        if (fits_all) begin
          pool_start_d = pool_start_q + total;
          ptr_d        = pool_start_q + total - size_x;
        end else if (fits_one) begin
          rem_d = left;
        end else if (left != '0) begin
          mem_we    = 1'b1;
          mem_waddr = pool_start_q[GSH +: GIDX_W];
          mem_wdata = heads_q[left_cls[CLS_W-1:0]];
          hd_we     = 1'b1;
          hd_idx    = left_cls[CLS_W-1:0];
          hd_wdata  = {1'b0, pool_start_q[GSH +: GIDX_W]};
        end
      end
      S_DIV: begin
        if (rem_ge) begin
          rem_d        = rem_q - size_x;
          pool_start_d = pool_start_q + size_x;
        end else begin
          ptr_d = pool_start_q - size_x;
        end
      end
      S_LINK: begin
        if (link_done) begin
          res_grant_d  = base_q[BADDR_W-1:0];
          res_status_d = ST_OK;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = ptr_q[GSH +: GIDX_W];
          mem_wdata = heads_q[cls_q];
          hd_we     = 1'b1;
          hd_idx    = cls_q;
          hd_wdata  = {1'b0, ptr_q[GSH +: GIDX_W]};
          ptr_d     = ptr_q - size_x;
        end
      end
      S_GROW: begin
        if (want_ok) begin
          arena_next_d = arena_next_q + want;
          heap_total_d = heap_total_q + want;
          if (last_pass) begin
            pool_start_d = '0;
            pool_end_d   = '0;
            res_grant_d  = '0;
            res_status_d = ST_OOM;
          end else begin
            pool_start_d = arena_next_q;
            pool_end_d   = arena_next_q + want;
            pass_d       = pass_q + PASS_W'(1);
          end
        end else if (found) begin
          mem_re       = 1'b1;
          mem_raddr    = bhead[GIDX_W-1:0];
          pop_cls_d    = bcls;
          borrow_d     = 1'b1;
          pool_start_d = ADDR_W'({bhead[GIDX_W-1:0], GSH'(0)});
          pool_end_d   = ADDR_W'({bhead[GIDX_W-1:0], GSH'(0)})
                       + (ADDR_W'({1'b0, bcls} + (CLS_W+1)'(1)) << GSH);
        end else begin
          pool_start_d = '0;
          pool_end_d   = '0;
          res_grant_d  = '0;
          res_status_d = ST_OOM;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          grant_d     = res_grant_q;
          status_d    = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= link_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_valid_i) begin
      mode_q <= mode_i;
      req_q  <= request_size_i;
      old_q  <= old_size_i;
      addr_q <= block_address_i;
    end
    cls_q       <= cls_d;
    size_q      <= size_d;
    base_q      <= base_d;
    ptr_q       <= ptr_d;
    rem_q       <= rem_d;
    pop_cls_q   <= pop_cls_d;
    res_grant_q <= res_grant_d;
    res_status_q <= res_status_d;
    grant_q     <= grant_d;
    status_q    <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      pool_start_q <= '0;
      pool_end_q   <= '0;
      heap_total_q <= '0;
      arena_next_q <= '0;
      pass_q       <= '0;
      borrow_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads_q[i] <= NIL;
      end
    end else begin
      st_q         <= st_d;
      pool_start_q <= pool_start_d;
      pool_end_q   <= pool_end_d;
      heap_total_q <= heap_total_d;
      arena_next_q <= arena_next_d;
      pass_q       <= pass_d;
      borrow_q     <= borrow_d;
      out_valid_q  <= out_valid_d;
      if (hd_we) begin
        heads_q[hd_idx] <= hd_wdata;
      end
    end
  end

  assign in_ready_o        = (st_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign granted_address_o = grant_q;
  assign status_o          = status_q;

  a_pool_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_IDLE |-> pool_start_q <= pool_end_q)
    else $error("pool bounds crossed");

  a_arena_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arena_next_q <= ADDR_W'(ARENA_BYTES))
    else $error("arena overrun");

  a_link_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_LINK |-> ptr_q >= base_q)
    else $error("link pointer below chunk base");

  a_grant_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> granted_address_o[GSH-1:0] == '0)
    else $error("unaligned grant");

endmodule
